### src/pms_pkg.sv
// Shared types and constants for the PCM mix, scale and saturate block.
// Used by every module under src; depends on nothing else.
package pms_pkg;

   // Register file geometry: five 32-bit registers at byte addresses 4*i.
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // Register word indexes (byte address divided by four).
   localparam logic [2:0] REG_SAMPLE_FORMAT = 3'd0;
   localparam logic [2:0] REG_SIGNED_CLIP   = 3'd1;
   localparam logic [2:0] REG_CLIP_MAX      = 3'd2;
   localparam logic [2:0] REG_CLIP_MIN      = 3'd3;
   localparam logic [2:0] REG_GAIN          = 3'd4;

   localparam int SAMPLE_W = 32;
   localparam int SUM_W    = SAMPLE_W + 1;
   localparam int GAIN_W   = 24;
   localparam int FRAC_W   = 16;
   localparam int PROD_W   = SUM_W + GAIN_W;
   localparam int SCALED_W = PROD_W - FRAC_W;

   typedef enum logic [1:0] {
      FMT_8  = 2'd0,
      FMT_16 = 2'd1,
      FMT_24 = 2'd2,
      FMT_32 = 2'd3
   } fmt_type;

   typedef struct packed {
      fmt_type                     sample_format;
      logic                        signed_clip;
      logic signed [SAMPLE_W-1:0]  clip_max;
      logic signed [SAMPLE_W-1:0]  clip_min;
      logic [GAIN_W-1:0]           gain;
   } cfg_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample_a;
      logic [SAMPLE_W-1:0] sample_b;
      logic                last;
   } req_type;

   // Sum of the two widened samples, held as sign and magnitude.
   typedef struct packed {
      logic [SUM_W-1:0] mag;
      logic             neg;
      logic             last;
   } sum_type;

   // Magnitude after gain, fraction bits already dropped.
   typedef struct packed {
      logic [SCALED_W-1:0] mag;
      logic                neg;
      logic                last;
   } scaled_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] mixed_word;
      logic                last;
   } rsp_type;

endpackage

### src/pcm_mix_scale_saturate.sv
// Top level of the saturating PCM mixer with gain.
// Depends on pms_pkg, pms_csr, pms_widen, pms_scale and pms_clip.
//
// Unless stalled, the block takes one item per clock: two raw little-endian
// sample words, sign-extended from the configured sample width (8, 16, 24 or
// 32 bits), added exactly, multiplied by an unsigned Q8.16 gain with the
// fraction truncated toward zero, saturated to the signed 32-bit range and
// then clipped to [clip_min, clip_max], or only at clip_max when signed_clip
// is zero. The result is packed back to the sample width with the upper bytes
// zero, and tlast is carried through unchanged. Scale-only operation is the
// same with sample_b tied to zero. The datapath is a three-stage pipeline:
// widening and add, the 33 by 24 bit gain multiplier, then saturation, clip
// and pack. Each stage has its own register and valid bit, so an accepted item
// passes through the widen, scale and clip registers in turn before its result
// is offered; the block sustains one item per cycle while results are taken;
// a stalled result only holds back the stages behind it once they are all full.
// Configuration registers are read live by the stages and
// should be written only while no items are in flight. There is no reset
// sweep: the block accepts items from the first cycle after reset.
module pcm_mix_scale_saturate (
   input  logic                             clock,
   input  logic                             reset,
   // Input items
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [63:0]                      req_tdata,  // [31:0] sample_a, [63:32] sample_b
   input  logic                             req_tlast,  // last_in
   // Result items
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [31:0]                      rsp_tdata,  // [31:0] mixed_word
   output logic                             rsp_tlast,  // last_out
   // Configuration
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [pms_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [pms_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [pms_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);
   import pms_pkg::*;

   cfg_type    cfg;
   req_type    req;
   sum_type    sum_data;
   scaled_type scaled_data;
   rsp_type    rsp;
   logic       sum_valid;
   logic       sum_ready;
   logic       scaled_valid;
   logic       scaled_ready;

   assign req.sample_a = req_tdata[31:0];
   assign req.sample_b = req_tdata[63:32];
   assign req.last     = req_tlast;

   pms_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   pms_widen u_widen (
      .clock         (clock),
      .reset         (reset),
      .sample_format (cfg.sample_format),
      .in_valid      (req_tvalid),
      .in_ready      (req_tready),
      .in_data       (req),
      .out_valid     (sum_valid),
      .out_ready     (sum_ready),
      .out_data      (sum_data)
   );

   pms_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .gain      (cfg.gain),
      .in_valid  (sum_valid),
      .in_ready  (sum_ready),
      .in_data   (sum_data),
      .out_valid (scaled_valid),
      .out_ready (scaled_ready),
      .out_data  (scaled_data)
   );

   pms_clip u_clip (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (scaled_valid),
      .in_ready  (scaled_ready),
      .in_data   (scaled_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp)
   );

   assign rsp_tdata = rsp.mixed_word;
   assign rsp_tlast = rsp.last;

`ifndef NO_ASSERTIONS
   // Input back-pressure only ever comes from a stalled, full pipeline.
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready && sum_valid && scaled_valid))
      else $error("input stalled while the pipeline has room");

   // An accepted item always lands in the first stage.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> sum_valid)
      else $error("accepted item lost at the first stage");

   // No result is offered straight after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");
`endif

endmodule

### src/pms_csr.sv
// Configuration register file with an APB-style access port.
// Depends on pms_pkg for the register indexes and the cfg_type bundle.
module pms_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [pms_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [pms_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [pms_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready,
   output pms_pkg::cfg_type                 cfg
);
   import pms_pkg::*;

   cfg_type    cfg_ff;
   logic       wr_en;
   logic [2:0] reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sample_format <= FMT_24;
         cfg_ff.signed_clip   <= 1'b1;
         cfg_ff.clip_max      <= 32'sd8388607;
         cfg_ff.clip_min      <= -32'sd8388608;
         cfg_ff.gain          <= 24'd65536;
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_SAMPLE_FORMAT: cfg_ff.sample_format <= fmt_type'(csr_pwdata[1:0]);
            REG_SIGNED_CLIP:   cfg_ff.signed_clip   <= csr_pwdata[0];
            REG_CLIP_MAX:      cfg_ff.clip_max      <= csr_pwdata;
            REG_CLIP_MIN:      cfg_ff.clip_min      <= csr_pwdata;
            REG_GAIN:          cfg_ff.gain          <= csr_pwdata[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_SAMPLE_FORMAT: csr_prdata = {30'd0, cfg_ff.sample_format};
         REG_SIGNED_CLIP:   csr_prdata = {31'd0, cfg_ff.signed_clip};
         REG_CLIP_MAX:      csr_prdata = cfg_ff.clip_max;
         REG_CLIP_MIN:      csr_prdata = cfg_ff.clip_min;
         REG_GAIN:          csr_prdata = {{(CSR_DATA_W-GAIN_W){1'b0}}, cfg_ff.gain};
         default:           csr_prdata = '0;
      endcase
   end

endmodule

### src/pms_widen.sv
// First stage: sign-extends both samples from the sample width and adds them,
// registering the sum as sign and magnitude. Depends on pms_pkg.
module pms_widen (
   input  logic              clock,
   input  logic              reset,
   input  pms_pkg::fmt_type  sample_format,
   input  logic              in_valid,
   output logic              in_ready,
   input  pms_pkg::req_type  in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output pms_pkg::sum_type  out_data
);
   import pms_pkg::*;

   logic                    valid_ff;
   logic                    valid_in;
   sum_type                 data_ff;
   sum_type                 data_in;
   logic signed [SUM_W-1:0] a_ext;
   logic signed [SUM_W-1:0] b_ext;
   logic signed [SUM_W-1:0] sum;

   function automatic logic signed [SUM_W-1:0] widen(input logic [SAMPLE_W-1:0] w,
                                                     input fmt_type f);
      logic signed [SUM_W-1:0] v;
      unique case (f)
         FMT_8:  v = {{(SUM_W-8){w[7]}}, w[7:0]};
         FMT_16: v = {{(SUM_W-16){w[15]}}, w[15:0]};
         FMT_24: v = {{(SUM_W-24){w[23]}}, w[23:0]};
         FMT_32: v = {w[31], w};
      endcase
      return v;
   endfunction

   always_comb begin
      a_ext         = widen(in_data.sample_a, sample_format);
      b_ext         = widen(in_data.sample_b, sample_format);
      sum           = a_ext + b_ext;
      data_in.neg   = sum[SUM_W-1];
      data_in.mag   = sum[SUM_W-1] ? (~sum + 1'b1) : sum;
      data_in.last  = in_data.last;
      in_ready      = !valid_ff || out_ready;
      valid_in      = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

`ifndef NO_ASSERTIONS
   // Two samples of at most 32 bits never give a magnitude above 2^32.
   assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> !(data_ff.mag[SUM_W-1] && (|data_ff.mag[SUM_W-2:0])))
      else $error("widened sum magnitude out of range");
`endif

endmodule

### src/pms_scale.sv
// Second stage: multiplies the sum magnitude by the Q8.16 gain and drops the
// fraction bits, which truncates toward zero. Depends on pms_pkg.
module pms_scale (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [pms_pkg::GAIN_W-1:0]  gain,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  pms_pkg::sum_type            in_data,
   output logic                        out_valid,
   input  logic                        out_ready,
   output pms_pkg::scaled_type         out_data
);
   import pms_pkg::*;

   logic              valid_ff;
   logic              valid_in;
   scaled_type        data_ff;
   scaled_type        data_in;
   logic [PROD_W-1:0] prod;

   always_comb begin
      prod         = {{GAIN_W{1'b0}}, in_data.mag} * {{SUM_W{1'b0}}, gain};
      data_in.mag  = prod[PROD_W-1:FRAC_W];
      data_in.neg  = in_data.neg;
      data_in.last = in_data.last;
      in_ready     = !valid_ff || out_ready;
      valid_in     = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

`ifndef NO_ASSERTIONS
   // Magnitude is at most 2^32 and gain below 2^24, so the top bit stays clear.
   assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> !data_ff.mag[SCALED_W-1])
      else $error("scaled magnitude exceeds its bound");
`endif

endmodule

### src/pms_clip.sv
// Last stage: restores the sign, saturates to 32 bits, clips to the
// configured bounds and packs to the sample width. Depends on pms_pkg.
module pms_clip (
   input  logic                 clock,
   input  logic                 reset,
   input  pms_pkg::cfg_type     cfg,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  pms_pkg::scaled_type  in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output pms_pkg::rsp_type     out_data
);
   import pms_pkg::*;

   logic                       valid_ff;
   logic                       valid_in;
   rsp_type                    data_ff;
   rsp_type                    data_in;
   logic signed [SAMPLE_W-1:0] sat;
   logic signed [SAMPLE_W-1:0] clipped;
   logic                       over_pos;
   logic                       over_neg;

   always_comb begin
      // Positive overflow above 2^31-1; negative overflow below -2^31.
      over_pos = !in_data.neg && (|in_data.mag[SCALED_W-1:SAMPLE_W-1]);
      over_neg = in_data.neg && ((|in_data.mag[SCALED_W-1:SAMPLE_W]) ||
                 (in_data.mag[SAMPLE_W-1] && (|in_data.mag[SAMPLE_W-2:0])));
      if (over_pos) begin
         sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
      end else if (over_neg) begin
         sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
      end else if (in_data.neg) begin
         sat = ~in_data.mag[SAMPLE_W-1:0] + 1'b1;
      end else begin
         sat = in_data.mag[SAMPLE_W-1:0];
      end

      // The upper bound is tested first, so it wins for a value beyond both bounds.
      if (sat > cfg.clip_max) begin
         clipped = cfg.clip_max;
      end else if (cfg.signed_clip && (sat < cfg.clip_min)) begin
         clipped = cfg.clip_min;
      end else begin
         clipped = sat;
      end

      case (cfg.sample_format)
         FMT_8:   data_in.mixed_word = {24'd0, clipped[7:0]};
         FMT_16:  data_in.mixed_word = {16'd0, clipped[15:0]};
         FMT_24:  data_in.mixed_word = {8'd0, clipped[23:0]};
         default: data_in.mixed_word = clipped;
      endcase
      data_in.last = in_data.last;

      in_ready = !valid_ff || out_ready;
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

`ifndef NO_ASSERTIONS
   // Saturation can only go one way, matching the sign of the value.
   assert property (@(posedge clock) disable iff (reset)
      in_valid |-> !(over_pos && over_neg))
      else $error("saturation flagged in both directions");
`endif

endmodule
